[hw/rtl/msl_pkg.sv]
// Shared types, register indices, constants and the sine table builder for the LFO.
package msl_pkg;

	// register indices on the configuration port
	localparam logic [2:0] REG_WAVE_SHAPE  = 3'd0;
	localparam logic [2:0] REG_SYNC_EN     = 3'd1;
	localparam logic [2:0] REG_SYNC_DIV    = 3'd2;
	localparam logic [2:0] REG_FREE_RATE   = 3'd3;
	localparam logic [2:0] REG_TEMPO       = 3'd4;
	localparam logic [2:0] REG_SAMPLE_RATE = 3'd5;
	localparam logic [2:0] REG_OFFSET      = 3'd6;
	localparam logic [2:0] REG_RETRIG_EN   = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// wave shape codes; anything else is sine
	localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
	localparam logic [2:0] SHAPE_SAW      = 3'd2;
	localparam logic [2:0] SHAPE_SQUARE   = 3'd3;
	localparam logic [2:0] SHAPE_STEP     = 3'd4;

	// input command codes
	localparam logic CMD_TICK       = 1'b0;
	localparam logic CMD_NOTE_START = 1'b1;

	// rate arithmetic: rate kept in 1/60000 Hz
	localparam int RATE_W    = 23;       // up to 4_800_000
	localparam int FS_W      = 18;
	localparam int DEN_W     = 34;       // 60000 * fs < 2^34
	localparam int RATE_PRE  = 7;        // quotient bits above the fraction
	localparam logic [DEN_W-1:0] RATE_DEN   = DEN_W'(60000);
	localparam logic [FS_W-1:0]  FS_DEFAULT = FS_W'(44100);

	typedef struct packed {
		logic [2:0]  wave_shape;
		logic        sync_enable;
		logic [1:0]  sync_division;
		logic [16:0] free_rate_millihertz;
		logic [8:0]  tempo_bpm;
		logic [17:0] sample_rate_hz;
		logic [15:0] phase_offset;
		logic        retrigger_enable;
	} cfg_t;

	// one queued item
	typedef struct packed {
		logic        note;
		logic [15:0] rnd;
	} item_t;

	// one entry of a full-period sine table, built by quarter-wave symmetry from a Q30 Taylor series;
	// evaluated at elaboration only
	function automatic logic signed [15:0] sine_entry(input int idx, input int lg);
		logic [63:0] q4, quad, r, n, x, x2, s, y, v;
		q4   = 64'(idx) * 64'd4;
		quad = (q4 >> lg) & 64'd3;
		r    = q4 & ((64'd1 << lg) - 64'd1);
		n    = quad[0] ? ((64'd1 << lg) - r) : r;
		x    = (n << 30) >> lg;
		x2   = (x * x) >> 30;
		s    = 64'd172273;
		s    = 64'd5026994    - ((x2 * s) >> 30);
		s    = 64'd85569278   - ((x2 * s) >> 30);
		s    = 64'd693598674  - ((x2 * s) >> 30);
		s    = 64'd1686629713 - ((x2 * s) >> 30);
		y    = (x * s) >> 30;
		v    = (y + 64'd16384) >> 15;
		if (v > 64'd32768) v = 64'd32768;
		if (quad[1]) return 16'(-v);
		return (v > 64'd32767) ? 16'sd32767 : 16'(v);
	endfunction

endpackage

[hw/rtl/msl_cfg.sv]
// Configuration register file of the LFO.
module msl_cfg
	import msl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_shape           <= SHAPE_TRIANGLE;
			cfg_q.sync_enable          <= 1'b1;
			cfg_q.sync_division        <= 2'd3;
			cfg_q.free_rate_millihertz <= 17'd1500;
			cfg_q.tempo_bpm            <= 9'd120;
			cfg_q.sample_rate_hz       <= 18'd44100;
			cfg_q.phase_offset         <= 16'd16384;
			cfg_q.retrigger_enable     <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WAVE_SHAPE:  cfg_q.wave_shape           <= cfg_data[2:0];
				REG_SYNC_EN:     cfg_q.sync_enable          <= cfg_data[0];
				REG_SYNC_DIV:    cfg_q.sync_division        <= cfg_data[1:0];
				REG_FREE_RATE:   cfg_q.free_rate_millihertz <= cfg_data[16:0];
				REG_TEMPO:       cfg_q.tempo_bpm            <= cfg_data[8:0];
				REG_SAMPLE_RATE: cfg_q.sample_rate_hz       <= cfg_data[17:0];
				REG_OFFSET:      cfg_q.phase_offset         <= cfg_data[15:0];
				REG_RETRIG_EN:   cfg_q.retrigger_enable     <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/msl_front.sv]
// Input side: takes transactions, drops inert note starts, queues the rest.
module msl_front
	import msl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] random_value,
	input  logic        retrigger_enable,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      item_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       accept, push;

	assign in_ready = (count_q != 2'd2);
	assign accept   = in_valid && in_ready;
	// a note start with retrigger off has no effect at all
	assign push     = accept && !(cmd == CMD_NOTE_START && !retrigger_enable);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = item_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q].note <= (cmd == CMD_NOTE_START);
			item_q[wr_ptr_q].rnd  <= random_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/msl_back.sv]
// Execution side: phase state, increment divider, waveform and output register.
module msl_back
	import msl_pkg::*;
#(
	parameter int PHASE_BITS       = 32,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] lfo_value
);

	localparam int LG    = $clog2(SINE_TABLE_DEPTH);
	localparam int QW    = PHASE_BITS + RATE_PRE;
	localparam int CW    = $clog2(QW);
	localparam int STEPS = QW - 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [PHASE_BITS-1:0] phase_q, p_q;
	logic [15:0]           held_q, rnd_q, out_q;
	logic                  ov_q;
	logic [DEN_W-1:0]      d_q, rem_q;
	logic [QW-1:0]         quo_q, nb_q;
	logic [CW-1:0]         cnt_q;
	logic signed [15:0]    lut_q;

	logic signed [15:0]    sine_lut [SINE_TABLE_DEPTH];
	logic [8:0]            bpm;
	logic [16:0]           mhz;
	logic [RATE_W-1:0]     rate;
	logic [FS_W-1:0]       fs_eff;
	logic [DEN_W:0]        trial;
	logic                  ge;
	logic [PHASE_BITS:0]   sum;
	logic                  wrap, fire;
	logic [16:0]           tri_t;
	logic signed [17:0]    tri_mid;
	logic [15:0]           wave;

	for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_lut
		assign sine_lut[g] = sine_entry(g, LG);
	end

	// rate in 1/60000 Hz; both branches already land inside 0.01..80 Hz
	always_comb begin
		bpm = cfg.tempo_bpm;
		if (bpm < 9'd20) bpm = 9'd20;
		if (bpm > 9'd300) bpm = 9'd300;
		mhz = cfg.free_rate_millihertz;
		if (mhz < 17'd10) mhz = 17'd10;
		if (mhz > 17'd80000) mhz = 17'd80000;
		if (cfg.sync_enable)
			rate = RATE_W'(bpm) * RATE_W'({1'b0, cfg.sync_division} + 3'd1) * RATE_W'(1000);
		else
			rate = RATE_W'(mhz) * RATE_W'(60);
	end

	assign fs_eff = (cfg.sample_rate_hz == '0) ? FS_DEFAULT : cfg.sample_rate_hz;

	// restoring division step
	assign trial = {rem_q, nb_q[QW-1]};
	assign ge    = (trial >= {1'b0, d_q});

	assign sum  = {1'b0, phase_q} + {1'b0, quo_q[PHASE_BITS-1:0]};
	assign wrap = (|quo_q[QW-1:PHASE_BITS]) || sum[PHASE_BITS];
	assign fire = (state_q == ST_DONE) && (!ov_q || out_ready);

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// waveform at the offset phase
	always_comb begin
		tri_t   = p_q[PHASE_BITS-1 -: 17];
		tri_mid = 18'sd65536 - signed'({1'b0, tri_t});
		unique case (cfg.wave_shape)
			SHAPE_TRIANGLE: begin
				if (tri_t < 17'd32768)
					wave = tri_t[15:0];
				else if (tri_t < 17'd98304)
					wave = (tri_mid > 18'sd32767) ? 16'h7fff : tri_mid[15:0];
				else
					wave = tri_t[15:0];
			end
			SHAPE_SAW:    wave = {~p_q[PHASE_BITS-1], p_q[PHASE_BITS-2 -: 15]};
			SHAPE_SQUARE: wave = p_q[PHASE_BITS-1] ? 16'h8000 : 16'h7fff;
			SHAPE_STEP:   wave = held_q;
			default:      wave = lut_q;
		endcase
	end

	assign out_valid = ov_q;
	assign lfo_value = out_q;

	always_ff @(posedge clk) begin
		lut_q <= sine_lut[p_q[PHASE_BITS-1 -: LG]];
		if (q_pop) begin
			p_q   <= phase_q + {cfg.phase_offset, (PHASE_BITS-16)'(0)};
			rnd_q <= q_item.rnd;
		end
		if (state_q == ST_LOAD) begin
			d_q   <= DEN_W'(fs_eff) * RATE_DEN;
			rem_q <= DEN_W'(rate >> RATE_PRE);
			nb_q  <= {rate[RATE_PRE-1:0], PHASE_BITS'(0)};
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, d_q}) : trial[DEN_W-1:0];
			nb_q  <= {nb_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
		if (fire) out_q <= wave;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			held_q  <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			// a new result replaces one leaving in the same cycle
			if (fire) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_item.note) begin
							phase_q <= '0;
							held_q  <= q_item.rnd;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					cnt_q   <= CW'(STEPS);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) state_q <= ST_DONE;
					else cnt_q <= cnt_q - CW'(1);
				end
				ST_DONE: begin
					if (fire) begin
						phase_q <= sum[PHASE_BITS-1:0];
						if (wrap) held_q <= rnd_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/multi_shape_lfo_top.sv]
// Top level of the multi-shape low-frequency oscillator.
//
// Channels: input transactions (cmd, random_value) on in_valid/in_ready,
// results (lfo_value, Q1.15) on out_valid/out_ready, and a register write
// channel (cfg_index, cfg_data) on cfg_valid/cfg_ready, always ready.
// A tick gives one lfo_value; a note start gives none and, with retrigger
// on, clears the phase and loads the held step from random_value.
// The back end takes one tick at a time and no new item before a tick's
// result is registered; its pace is set by the bit-serial divider forming
// the phase increment rate / (60000 * sample rate), one quotient bit per
// cycle over PHASE_BITS + 7 bits. A note start is applied in the back end
// as it leaves the queue, without running the divider.
// A two-entry queue between the input side and the execution side keeps
// taking transactions while the divider runs; the output register lets
// the next tick start while a result waits.
// Reset clears phase and held step and loads the register defaults.
// A stalled receiver holds the result; the back end waits at the end of
// the following tick and the queue then fills and drops in_ready.
// The user must write registers only while the block is idle; the block itself does not enforce this.
module multi_shape_lfo_top
	import msl_pkg::*;
#(
	parameter int PHASE_BITS       = 32,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [15:0]           random_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           lfo_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	item_t q_item;
	logic  q_valid, q_pop;

	msl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// front end: classify and queue
	msl_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.random_value     (random_value),
		.retrigger_enable (cfg.retrigger_enable),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop)
	);

	// back end: oscillator state, divider, waveform, output register
	msl_back #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.lfo_value (lfo_value)
	);

endmodule
